// ----- design/hrsa_pkg.sv -----
// ----------------------------------------------------------------------------
// hrsa_pkg: shared types and constants for the heat rise smoke alarm
// Item structs, register indexes, scaling constants and the tone duty table.
// ----------------------------------------------------------------------------
package hrsa_pkg;

	// Widths of the item fields and registers.
	localparam int RAW_W    = 10;
	localparam int DEG_W    = 9;
	localparam int LEVEL_W  = 3;
	localparam int DUTY_W   = 8;
	localparam int BAND_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// Ring depth default for the temperature history.
	localparam int HISTORY_DEPTH_DEF = 3;

	// Degrees are raw * 500 / 1024.
	localparam int DEG_SCALE = 500;
	localparam int DEG_SHIFT = 10;
	localparam int PROD_W    = RAW_W + 9;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SMOKE_THRESHOLD  = 3'd0,
		REG_RISE_LIMIT_ONE   = 3'd1,
		REG_RISE_LIMIT_TWO   = 3'd2,
		REG_RISE_LIMIT_THREE = 3'd3,
		REG_RISE_LIMIT_FOUR  = 3'd4,
		REG_BAND_FLOOR       = 3'd5,
		REG_BAND_WARM        = 3'd6,
		REG_BAND_HOT         = 3'd7
	} cfg_reg_t;

	// Register reset values.
	localparam logic [RAW_W-1:0] SMOKE_THRESHOLD_RST  = 10'd290;
	localparam logic [DEG_W-1:0] RISE_LIMIT_ONE_RST   = 9'd1;
	localparam logic [DEG_W-1:0] RISE_LIMIT_TWO_RST   = 9'd2;
	localparam logic [DEG_W-1:0] RISE_LIMIT_THREE_RST = 9'd4;
	localparam logic [DEG_W-1:0] RISE_LIMIT_FOUR_RST  = 9'd5;
	localparam logic [DEG_W-1:0] BAND_FLOOR_RST       = 9'd22;
	localparam logic [DEG_W-1:0] BAND_WARM_RST        = 9'd35;
	localparam logic [DEG_W-1:0] BAND_HOT_RST         = 9'd42;

	// Alarm levels.
	localparam logic [LEVEL_W-1:0] LEVEL_NONE  = 3'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 3'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 3'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_THREE = 3'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_FOUR  = 3'd4;

	// Temperature bands.
	localparam logic [BAND_W-1:0] BAND_BELOW  = 2'd0;
	localparam logic [BAND_W-1:0] BAND_NORMAL = 2'd1;
	localparam logic [BAND_W-1:0] BAND_WARMER = 2'd2;
	localparam logic [BAND_W-1:0] BAND_HOTTER = 2'd3;

	// Speaker compare values per level.
	localparam logic [DUTY_W-1:0] DUTY_L0 = 8'd0;
	localparam logic [DUTY_W-1:0] DUTY_L1 = 8'd50;
	localparam logic [DUTY_W-1:0] DUTY_L2 = 8'd70;
	localparam logic [DUTY_W-1:0] DUTY_L3 = 8'd90;
	localparam logic [DUTY_W-1:0] DUTY_L4 = 8'd130;

	typedef struct packed {
		logic [RAW_W-1:0] temp_raw;
		logic [RAW_W-1:0] smoke_raw;
	} in_item_t;

	typedef struct packed {
		logic [DEG_W-1:0]   temp_degrees;
		logic [LEVEL_W-1:0] alarm_level;
		logic [DUTY_W-1:0]  tone_duty;
		logic               buzzer_on;
		logic               led_alarm;
		logic               led_warning;
		logic               led_smoke;
		logic [BAND_W-1:0]  temp_band;
	} out_item_t;

	function automatic logic [DUTY_W-1:0] duty_of_level(input logic [LEVEL_W-1:0] level);
		logic [DUTY_W-1:0] duty;
		case (level)
			LEVEL_ONE:   duty = DUTY_L1;
			LEVEL_TWO:   duty = DUTY_L2;
			LEVEL_THREE: duty = DUTY_L3;
			LEVEL_FOUR:  duty = DUTY_L4;
			default:     duty = DUTY_L0;
		endcase
		return duty;
	endfunction

endpackage

// ----- design/heat_rise_smoke_alarm.sv -----
// ----------------------------------------------------------------------------
// heat_rise_smoke_alarm: rate-of-rise fire alarm with smoke gating
// Scales each temperature sample, keeps a short ring of past samples and
// grades the largest rise into an alarm level while smoke is present.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload                    Direction
//  -------   ---------------------  -------------------------  ---------
//  in        in_valid / in_stall    in_item  (hrsa_pkg::in_item_t)   into block
//  out       out_valid / out_stall  out_item (hrsa_pkg::out_item_t)  out of block
//  cfg       cfg_we                 cfg_index, cfg_data              into block
//
// Each item passes through the input register and then sits in the
// result register until it is taken, and one item is accepted every cycle
// while the output side keeps up.
// All grading is done by a short compare tree in the cycle between the two
// registers; the ring depth sets the width of that tree.
// A stall on the output holds the result register and, when the input
// register is also full, raises in_stall in the same cycle.
// Reset clears the control state and restores every register to its
// default; the history ring needs no clearing since the first item fills it.

module heat_rise_smoke_alarm #(
	parameter int HISTORY_DEPTH = hrsa_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  hrsa_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output hrsa_pkg::out_item_t               out_item,
	input  logic                              cfg_we,
	input  logic [hrsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hrsa_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(HISTORY_DEPTH - 1);

	// Configuration registers.
	logic [hrsa_pkg::RAW_W-1:0] smoke_threshold_q;
	logic [hrsa_pkg::DEG_W-1:0] rise_limit_one_q;
	logic [hrsa_pkg::DEG_W-1:0] rise_limit_two_q;
	logic [hrsa_pkg::DEG_W-1:0] rise_limit_three_q;
	logic [hrsa_pkg::DEG_W-1:0] rise_limit_four_q;
	logic [hrsa_pkg::DEG_W-1:0] band_floor_q;
	logic [hrsa_pkg::DEG_W-1:0] band_warm_q;
	logic [hrsa_pkg::DEG_W-1:0] band_hot_q;

	// Input register.
	logic               valid_s1;
	hrsa_pkg::in_item_t item_s1;

	// Result register.
	logic                out_valid_q;
	hrsa_pkg::out_item_t out_item_q;

	// Alarm state.
	logic [hrsa_pkg::DEG_W-1:0] hist_q [HISTORY_DEPTH];
	logic [IDX_W-1:0]           slot_q;
	logic                       first_q;
	logic                       warning_q;
	logic                       smoke_lamp_q;

	// Datapath between the registers.
	logic                        advance;
	logic [hrsa_pkg::PROD_W-1:0] prod;
	logic [hrsa_pkg::DEG_W-1:0]  temp;
	logic                        smoke_present;
	logic                        armed;
	logic [hrsa_pkg::DEG_W-1:0]  best_rise;
	logic [hrsa_pkg::LEVEL_W-1:0] level;
	logic                        warning_next;
	logic                        smoke_lamp_next;
	logic [hrsa_pkg::BAND_W-1:0] band;
	hrsa_pkg::out_item_t         result;

	// The item in the input register moves on when the result register is
	// free or is being emptied in this cycle.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoke_threshold_q  <= hrsa_pkg::SMOKE_THRESHOLD_RST;
			rise_limit_one_q   <= hrsa_pkg::RISE_LIMIT_ONE_RST;
			rise_limit_two_q   <= hrsa_pkg::RISE_LIMIT_TWO_RST;
			rise_limit_three_q <= hrsa_pkg::RISE_LIMIT_THREE_RST;
			rise_limit_four_q  <= hrsa_pkg::RISE_LIMIT_FOUR_RST;
			band_floor_q       <= hrsa_pkg::BAND_FLOOR_RST;
			band_warm_q        <= hrsa_pkg::BAND_WARM_RST;
			band_hot_q         <= hrsa_pkg::BAND_HOT_RST;
		end else if (cfg_we) begin
			case (hrsa_pkg::cfg_reg_t'(cfg_index))
				hrsa_pkg::REG_SMOKE_THRESHOLD:  smoke_threshold_q  <= cfg_data;
				hrsa_pkg::REG_RISE_LIMIT_ONE:   rise_limit_one_q   <= cfg_data[8:0];
				hrsa_pkg::REG_RISE_LIMIT_TWO:   rise_limit_two_q   <= cfg_data[8:0];
				hrsa_pkg::REG_RISE_LIMIT_THREE: rise_limit_three_q <= cfg_data[8:0];
				hrsa_pkg::REG_RISE_LIMIT_FOUR:  rise_limit_four_q  <= cfg_data[8:0];
				hrsa_pkg::REG_BAND_FLOOR:       band_floor_q       <= cfg_data[8:0];
				hrsa_pkg::REG_BAND_WARM:        band_warm_q        <= cfg_data[8:0];
				hrsa_pkg::REG_BAND_HOT:         band_hot_q         <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Input register: a new item is taken whenever the register is empty or
	// its current item moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// Scale to degrees: the product needs 19 bits, the top nine are degrees.
	assign prod = hrsa_pkg::PROD_W'(item_s1.temp_raw) * hrsa_pkg::PROD_W'(hrsa_pkg::DEG_SCALE);
	assign temp = prod[hrsa_pkg::PROD_W-1:hrsa_pkg::DEG_SHIFT];

	assign smoke_present = item_s1.smoke_raw < smoke_threshold_q;
	assign armed         = smoke_present && !first_q;

	// Largest rise over the ring as it stands after this item's write. The
	// slot being written, and every slot on the first item, gives a rise of
	// zero, so those are simply skipped. A fall never counts.
	always_comb begin
		logic [hrsa_pkg::DEG_W-1:0] rise;
		best_rise = '0;
		for (int k = 0; k < HISTORY_DEPTH; k++) begin
			rise = temp - hist_q[k];
			if (!first_q && slot_q != IDX_W'(k) && temp > hist_q[k] && rise > best_rise) begin
				best_rise = rise;
			end
		end
	end

	always_comb begin
		level = hrsa_pkg::LEVEL_NONE;
		if (armed) begin
			if (best_rise > rise_limit_four_q) begin
				level = hrsa_pkg::LEVEL_FOUR;
			end else if (best_rise > rise_limit_three_q) begin
				level = hrsa_pkg::LEVEL_THREE;
			end else if (best_rise > rise_limit_two_q) begin
				level = hrsa_pkg::LEVEL_TWO;
			end else if (best_rise > rise_limit_one_q) begin
				level = hrsa_pkg::LEVEL_ONE;
			end
		end
	end

	// The warning lamp follows levels one and two, is cleared at level zero
	// and keeps its state through levels three and four.
	always_comb begin
		case (level)
			hrsa_pkg::LEVEL_NONE:                   warning_next = 1'b0;
			hrsa_pkg::LEVEL_ONE, hrsa_pkg::LEVEL_TWO: warning_next = 1'b1;
			default:                                warning_next = warning_q;
		endcase
	end

	// The smoke lamp clears without smoke, sets with smoke after the first
	// item, and holds when smoke shows on the first item.
	always_comb begin
		if (!smoke_present) begin
			smoke_lamp_next = 1'b0;
		end else if (!first_q) begin
			smoke_lamp_next = 1'b1;
		end else begin
			smoke_lamp_next = smoke_lamp_q;
		end
	end

	always_comb begin
		if (temp > band_floor_q && temp <= band_warm_q) begin
			band = hrsa_pkg::BAND_NORMAL;
		end else if (temp > band_warm_q && temp <= band_hot_q) begin
			band = hrsa_pkg::BAND_WARMER;
		end else if (temp > band_hot_q) begin
			band = hrsa_pkg::BAND_HOTTER;
		end else begin
			band = hrsa_pkg::BAND_BELOW;
		end
	end

	always_comb begin
		result.temp_degrees = temp;
		result.alarm_level  = level;
		result.tone_duty    = hrsa_pkg::duty_of_level(level);
		result.buzzer_on    = level >= hrsa_pkg::LEVEL_THREE;
		result.led_alarm    = level >= hrsa_pkg::LEVEL_THREE;
		result.led_warning  = warning_next;
		result.led_smoke    = smoke_lamp_next;
		result.temp_band    = band;
	end

	// Alarm state moves only when an item passes into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q       <= '0;
			first_q      <= 1'b1;
			warning_q    <= 1'b0;
			smoke_lamp_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			slot_q       <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			first_q      <= 1'b0;
			warning_q    <= warning_next;
			smoke_lamp_q <= smoke_lamp_next;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			for (int k = 0; k < HISTORY_DEPTH; k++) begin
				if (first_q || slot_q == IDX_W'(k)) begin
					hist_q[k] <= temp;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ----- design/hrsa_checker.sv -----
// ----------------------------------------------------------------------------
// hrsa_checker: port-level checks for the heat rise smoke alarm
// Watches the result channel and the consistency of the result fields.
// ----------------------------------------------------------------------------
module hrsa_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input hrsa_pkg::out_item_t out_item
);

	// A stalled result stays in place until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// Buzzer, alarm lamp and tone duty all follow the level.
	a_high_outputs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.buzzer_on == (out_item.alarm_level >= hrsa_pkg::LEVEL_THREE))
			&& (out_item.led_alarm == out_item.buzzer_on)
			&& (out_item.tone_duty == hrsa_pkg::duty_of_level(out_item.alarm_level)))
		else $error("alarm outputs disagree with level");

	// The warning lamp is on at levels one and two and off at level zero.
	a_warning: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.alarm_level == hrsa_pkg::LEVEL_ONE
			|| out_item.alarm_level == hrsa_pkg::LEVEL_TWO) |-> out_item.led_warning)
		else $error("warning lamp off at low level");

	a_warning_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.alarm_level == hrsa_pkg::LEVEL_NONE |-> !out_item.led_warning)
		else $error("warning lamp on at level zero");

	// An alarm is graded only while smoke is present.
	a_level_needs_smoke: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.alarm_level != hrsa_pkg::LEVEL_NONE |-> out_item.led_smoke)
		else $error("alarm level without smoke lamp");

endmodule

bind heat_rise_smoke_alarm hrsa_checker u_hrsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// ----- test/heat_rise_smoke_alarm_tb.sv -----
// ----------------------------------------------------------------------------
// heat_rise_smoke_alarm_tb: self-checking bench for the heat rise smoke alarm
// Feeds sensor samples through the input channel under random gaps and output
// stalls. Each accepted item is graded by a bench-side alarm model, and every
// result leaving the block is compared field by field with its expectation.
// Several register settings are used, the all-zero and all-ones extremes
// among them.
// ----------------------------------------------------------------------------
module heat_rise_smoke_alarm_tb;
	import hrsa_pkg::*;

	localparam int DEPTH        = HISTORY_DEPTH_DEF;
	localparam int IDLE_LIMIT   = 5000;
	localparam int SQUEEZE_LEN  = 200;
	localparam int DRAIN_CYCLES = 4;
	localparam int NUM_PHASES   = 7;
	localparam int NUM_DIRECTED = 24;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_item_t              in_item   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_item;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	heat_rise_smoke_alarm u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Samples waiting to be offered, and the graded results still owed by
	// the block, oldest first.
	in_item_t  sample_q[$];
	out_item_t alarm_q[$];

	// Bench copy of the register file. It is only changed while the block
	// is drained, so the alarm model always grades with the settings the
	// hardware uses.
	logic [RAW_W-1:0] smoke_thr_sh   = SMOKE_THRESHOLD_RST;
	logic [DEG_W-1:0] rise_lim_sh[4] = '{RISE_LIMIT_ONE_RST, RISE_LIMIT_TWO_RST,
		RISE_LIMIT_THREE_RST, RISE_LIMIT_FOUR_RST};
	logic [DEG_W-1:0] floor_sh       = BAND_FLOOR_RST;
	logic [DEG_W-1:0] warm_sh        = BAND_WARM_RST;
	logic [DEG_W-1:0] hot_sh         = BAND_HOT_RST;
	logic [CFG_DATA_W-1:0] reg_plan[8];

	// Bench copy of the alarm state. The ring starts at zero here, which
	// never matters since the first sample overwrites every slot.
	logic [DEG_W-1:0] ring_sh[DEPTH] = '{default: '0};
	int               slot_sh        = 0;
	logic             first_sh       = 1'b1;
	logic             warn_sh        = 1'b0;
	logic             lamp_sh        = 1'b0;

	// Bookkeeping for the run.
	int        errors        = 0;
	int        samples_in    = 0;
	int        results_seen  = 0;
	int        settings_used = 1;
	int        level_seen[5] = '{default: 0};
	int        warn_lit      = 0;
	int        walk_raw      = 0;
	int        tx_gap        = 0;
	int        rx_hold       = 0;
	int        quiet_cycles  = 0;
	logic [6:0] cycle_no     = '0;
	logic      calm          = 1'b0;
	logic      squeeze_req   = 1'b0;
	logic      squeeze_done  = 1'b0;
	out_item_t head_alarm;

	// Directed opening: first sample with smoke present, a hard fall, the
	// smoke threshold from both sides, a ramp that walks the levels up to
	// four and back, the latch held at high levels, and the field extremes.
	logic [RAW_W-1:0] dir_temp[NUM_DIRECTED] = '{
		10'd1023, 10'd0,    10'd0,    10'd0,   10'd0,   10'd4,   10'd5,   10'd9,
		10'd16,   10'd32,   10'd64,   10'd128, 10'd128, 10'd128, 10'd140, 10'd147,
		10'd200,  10'd300,  10'd300,  10'd1023, 10'd1023, 10'd0,  10'd512, 10'd341};
	logic [RAW_W-1:0] dir_smoke[NUM_DIRECTED] = '{
		10'd0,    10'd1023, 10'd0,    10'd289, 10'd290, 10'd0,   10'd0,   10'd0,
		10'd0,    10'd0,    10'd0,    10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
		10'd0,    10'd0,    10'd1023, 10'd0,   10'd0,   10'd0,   10'd512, 10'd682};

	// Grades one sample against the bench state and advances that state,
	// exactly as the block does when it takes the item.
	function automatic out_item_t grade_sample(input in_item_t s);
		out_item_t             r;
		logic [DEG_W-1:0]      deg;
		logic                  smoke_on;
		logic                  armed;
		int                    best;
		int                    rise;
		logic [LEVEL_W-1:0]    lvl;
		deg      = DEG_W'((32'(s.temp_raw) * DEG_SCALE) >> DEG_SHIFT);
		smoke_on = s.smoke_raw < smoke_thr_sh;
		armed    = smoke_on && !first_sh;
		// Smoke seen on the very first sample leaves the lamp as it was.
		if (!smoke_on) begin
			lamp_sh = 1'b0;
		end else if (!first_sh) begin
			lamp_sh = 1'b1;
		end
		if (first_sh) begin
			for (int k = 0; k < DEPTH; k++) ring_sh[k] = deg;
		end else begin
			ring_sh[slot_sh] = deg;
		end
		slot_sh  = (slot_sh + 1 >= DEPTH) ? 0 : slot_sh + 1;
		first_sh = 1'b0;
		// Rises are signed, so a falling temperature contributes nothing.
		best = 0;
		for (int k = 0; k < DEPTH; k++) begin
			rise = int'(deg) - int'(ring_sh[k]);
			if (rise > best) best = rise;
		end
		lvl = LEVEL_NONE;
		if (armed) begin
			if (best > int'(rise_lim_sh[3])) lvl = LEVEL_FOUR;
			else if (best > int'(rise_lim_sh[2])) lvl = LEVEL_THREE;
			else if (best > int'(rise_lim_sh[1])) lvl = LEVEL_TWO;
			else if (best > int'(rise_lim_sh[0])) lvl = LEVEL_ONE;
		end
		// The warning lamp is set by the low levels and held by the high ones.
		if (lvl == LEVEL_NONE) warn_sh = 1'b0;
		else if (lvl <= LEVEL_TWO) warn_sh = 1'b1;
		r.temp_degrees = deg;
		r.alarm_level  = lvl;
		case (lvl)
			LEVEL_ONE:   r.tone_duty = DUTY_L1;
			LEVEL_TWO:   r.tone_duty = DUTY_L2;
			LEVEL_THREE: r.tone_duty = DUTY_L3;
			LEVEL_FOUR:  r.tone_duty = DUTY_L4;
			default:     r.tone_duty = DUTY_L0;
		endcase
		r.buzzer_on   = lvl >= LEVEL_THREE;
		r.led_alarm   = lvl >= LEVEL_THREE;
		r.led_warning = warn_sh;
		r.led_smoke   = lamp_sh;
		if (deg > floor_sh && deg <= warm_sh) r.temp_band = BAND_NORMAL;
		else if (deg > warm_sh && deg <= hot_sh) r.temp_band = BAND_WARMER;
		else if (deg > hot_sh) r.temp_band = BAND_HOTTER;
		else r.temp_band = BAND_BELOW;
		return r;
	endfunction

	// Random samples. Most follow a drifting temperature with smoke present,
	// which is what reaches the rise grading; the rest are sudden jumps and
	// fully random noise.
	function automatic in_item_t make_sample();
		in_item_t s;
		int       pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			s.temp_raw  = RAW_W'($urandom_range(0, 1023));
			s.smoke_raw = RAW_W'($urandom_range(0, 1023));
			return s;
		end
		if (pick < 25) begin
			walk_raw = $urandom_range(0, 1023);
		end else begin
			walk_raw = walk_raw + $urandom_range(0, 40) - 16;
			if (walk_raw < 0) walk_raw = 0;
			if (walk_raw > 1023) walk_raw = 1023;
		end
		s.temp_raw = RAW_W'(walk_raw);
		if (smoke_thr_sh != '0 && $urandom_range(0, 99) < 80) begin
			s.smoke_raw = RAW_W'($urandom_range(0, int'(smoke_thr_sh) - 1));
		end else begin
			s.smoke_raw = RAW_W'($urandom_range(0, 1023));
		end
		return s;
	endfunction

	// Length of an idle stretch: mostly none or short, now and then long.
	function automatic int pause_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return 0;
		if (pick < 88) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	task automatic shadow_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_SMOKE_THRESHOLD:  smoke_thr_sh   = d;
			REG_RISE_LIMIT_ONE:   rise_lim_sh[0] = d[DEG_W-1:0];
			REG_RISE_LIMIT_TWO:   rise_lim_sh[1] = d[DEG_W-1:0];
			REG_RISE_LIMIT_THREE: rise_lim_sh[2] = d[DEG_W-1:0];
			REG_RISE_LIMIT_FOUR:  rise_lim_sh[3] = d[DEG_W-1:0];
			REG_BAND_FLOOR:       floor_sh       = d[DEG_W-1:0];
			REG_BAND_WARM:        warm_sh        = d[DEG_W-1:0];
			REG_BAND_HOT:         hot_sh         = d[DEG_W-1:0];
			default: ;
		endcase
	endtask

	// Writes the whole register plan, one register per cycle, keeping the
	// write enable high across the burst.
	task automatic write_regs();
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data  <= reg_plan[i];
			shadow_write(cfg_reg_t'(i), reg_plan[i]);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until nothing is queued, offered or owed, sampled at the falling
	// edge where every handshake signal has settled, then lets the pipeline
	// run dry.
	task automatic wait_drained();
		while (sample_q.size() != 0 || alarm_q.size() != 0 || in_valid) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] want_v,
		input logic [15:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
		end
	endtask

	// Sender. An item is taken at an edge where valid is high and stall is
	// low; at that same edge the alarm model grades it. While the block
	// stalls, the offered item is held unchanged.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
			tx_gap   <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				alarm_q.push_back(grade_sample(in_item));
				samples_in++;
			end
			if (!(in_valid && in_stall)) begin
				if (tx_gap != 0) begin
					in_valid <= 1'b0;
					tx_gap   <= tx_gap - 1;
				end else if (sample_q.size() != 0) begin
					in_item  <= sample_q.pop_front();
					in_valid <= 1'b1;
					tx_gap   <= calm ? 0 : pause_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Each result taken is checked against the oldest graded
	// sample. Stall is raised at random, and once for a long stretch so the
	// block backs up into its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_hold   <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (alarm_q.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected, got %p", $time, out_item);
				end else begin
					head_alarm = alarm_q.pop_front();
					check_field("temp_degrees", 16'(head_alarm.temp_degrees),
						16'(out_item.temp_degrees));
					check_field("alarm_level", 16'(head_alarm.alarm_level),
						16'(out_item.alarm_level));
					check_field("tone_duty", 16'(head_alarm.tone_duty),
						16'(out_item.tone_duty));
					check_field("buzzer_on", 16'(head_alarm.buzzer_on),
						16'(out_item.buzzer_on));
					check_field("led_alarm", 16'(head_alarm.led_alarm),
						16'(out_item.led_alarm));
					check_field("led_warning", 16'(head_alarm.led_warning),
						16'(out_item.led_warning));
					check_field("led_smoke", 16'(head_alarm.led_smoke),
						16'(out_item.led_smoke));
					check_field("temp_band", 16'(head_alarm.temp_band),
						16'(out_item.temp_band));
					results_seen++;
					if (head_alarm.alarm_level <= LEVEL_FOUR) level_seen[head_alarm.alarm_level]++;
					if (head_alarm.led_warning) warn_lit++;
				end
			end
			if (rx_hold != 0) begin
				out_stall <= 1'b1;
				rx_hold   <= rx_hold - 1;
			end else if (squeeze_req && !squeeze_done) begin
				out_stall    <= 1'b1;
				rx_hold      <= SQUEEZE_LEN - 1;
				squeeze_done <= 1'b1;
			end else if (!calm && $urandom_range(0, 99) < 30) begin
				out_stall <= 1'b1;
				rx_hold   <= pause_len();
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on forward progress, plus the switch that now and then turns
	// off all random idling until the seven-bit cycle counter next wraps.
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_no <= cycle_no + 1'b1;
			if (cycle_no == '0) calm <= ($urandom_range(0, 3) == 0);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == IDLE_LIMIT) begin
				$display("%0t: no item moved for %0d cycles, %0d results outstanding",
					$time, IDLE_LIMIT, alarm_q.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Phase sequencer. Phase 0 runs on the reset settings with the directed
	// samples first; the later phases change every register while the block
	// is drained: all ones, all zeros, plausible ordered settings, raw random
	// data (bits above a register's width are dropped by the block), ordered
	// settings again, and finally the reset values written back explicitly.
	initial begin
		int phase_len[NUM_PHASES];
		int lo;
		int mid;
		phase_len = '{250, 150, 150, 300, 250, 300, 100};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph != 0) begin
				wait_drained();
				case (ph)
					1: reg_plan = '{default: '1};
					2: reg_plan = '{default: '0};
					3, 5: begin
						reg_plan[0] = CFG_DATA_W'($urandom_range(100, 1000));
						lo          = $urandom_range(0, 3);
						reg_plan[1] = CFG_DATA_W'(lo);
						lo          = lo + $urandom_range(0, 4);
						reg_plan[2] = CFG_DATA_W'(lo);
						lo          = lo + $urandom_range(0, 4);
						reg_plan[3] = CFG_DATA_W'(lo);
						lo          = lo + $urandom_range(0, 6);
						reg_plan[4] = CFG_DATA_W'(lo);
						mid         = $urandom_range(0, 200);
						reg_plan[5] = CFG_DATA_W'(mid);
						mid         = mid + $urandom_range(0, 150);
						reg_plan[6] = CFG_DATA_W'(mid);
						mid         = mid + $urandom_range(0, 150);
						reg_plan[7] = CFG_DATA_W'(mid);
					end
					4: begin
						for (int i = 0; i < 8; i++) reg_plan[i] = CFG_DATA_W'($urandom_range(0, 1023));
					end
					default: begin
						reg_plan[0] = SMOKE_THRESHOLD_RST;
						reg_plan[1] = CFG_DATA_W'(RISE_LIMIT_ONE_RST);
						reg_plan[2] = CFG_DATA_W'(RISE_LIMIT_TWO_RST);
						reg_plan[3] = CFG_DATA_W'(RISE_LIMIT_THREE_RST);
						reg_plan[4] = CFG_DATA_W'(RISE_LIMIT_FOUR_RST);
						reg_plan[5] = CFG_DATA_W'(BAND_FLOOR_RST);
						reg_plan[6] = CFG_DATA_W'(BAND_WARM_RST);
						reg_plan[7] = CFG_DATA_W'(BAND_HOT_RST);
					end
				endcase
				write_regs();
				settings_used++;
			end
			@(negedge clk);
			if (ph == 0) begin
				for (int i = 0; i < NUM_DIRECTED; i++) begin
					sample_q.push_back('{temp_raw: dir_temp[i], smoke_raw: dir_smoke[i]});
				end
			end
			for (int i = 0; i < phase_len[ph]; i++) sample_q.push_back(make_sample());
			// With a full phase queued, ask the receiver for its long hold.
			if (ph == 0) squeeze_req = 1'b1;
		end
		wait_drained();
		if (alarm_q.size() != 0) begin
			errors++;
			$display("%0t: %0d expected results never arrived", $time, alarm_q.size());
		end
		$display("Graded %0d samples under %0d register settings, with a %0d-cycle output hold.",
			samples_in, settings_used, SQUEEZE_LEN);
		$display("Levels 0-4 seen %0d/%0d/%0d/%0d/%0d times; warning lamp lit on %0d results.",
			level_seen[0], level_seen[1], level_seen[2], level_seen[3], level_seen[4], warn_lit);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/hrsa_pkg.sv
design/heat_rise_smoke_alarm.sv
design/hrsa_checker.sv
test/heat_rise_smoke_alarm_tb.sv
